### src/bec_pkg.sv
// Package with the request and response types and the constants of the bubble event counter.
package bec_pkg;

   localparam int SAMPLE_W = 8;
   localparam int VIEW_W   = 9;
   localparam int COUNT_W  = 16;
   localparam int LOGGED_W = 10;

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 8'd80;
   localparam logic [COUNT_W-1:0]  COUNT_MAX       = 16'hFFFF;

   typedef enum logic {
      FUNC_SAMPLE = 1'b0,
      FUNC_TICK   = 1'b1
   } func_type;

   typedef struct packed {
      func_type            func;
      logic [SAMPLE_W-1:0] sample;
      logic [VIEW_W-1:0]   view_index;
   } req_type;

   typedef struct packed {
      logic                bubble_seen;
      logic [COUNT_W-1:0]  period_count;
      logic [LOGGED_W-1:0] periods_logged;
      logic                finished;
      logic [COUNT_W-1:0]  viewed_count;
   } rsp_type;

endpackage

### src/bubble_event_counter_with_log_top.sv
// Top level of the bubble event counter with its per-period history memory.
//
//   Port group   Direction   Handshake              Payload
//   req_         in          req_valid/req_ready    req_data (func, sample, view_index)
//   rsp_         out         rsp_valid/rsp_ready    rsp_data (counts, flags, viewed entry)
//   csr_         in          csr_wr_en              csr_wr_data (level threshold)
//
// One request is accepted per cycle while not stalled; the response passes s1, then out.
// The rate is set by the single write port and single read port of the history memory,
// which are both used at the cycle of acceptance; a same-slot write is forwarded.
// Reset is synchronous and clears all control state; the history memory is not cleared.
// A stalled response holds in the output register while one more request is taken.
module bubble_event_counter_with_log_top #(
   parameter int HISTORY_DEPTH = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bec_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bec_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data
);
   import bec_pkg::*;

   localparam int SLOT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int ADDR_W = $clog2(HISTORY_DEPTH);
   localparam int CMP_W  = (SLOT_W > VIEW_W) ? SLOT_W : VIEW_W;

   logic [SAMPLE_W-1:0] threshold_ff;
   logic                armed_ff, armed_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0]   slots_ff, slots_in;
   logic                done_ff, done_in;

   logic [COUNT_W-1:0]  hist_mem [HISTORY_DEPTH];
   logic [COUNT_W-1:0]  rd_data_ff;

   logic                s1_valid_ff, s1_valid_in;
   rsp_type             s1_rsp_ff, s1_rsp_in;
   logic                s1_view_ok_ff, s1_view_ok_in;
   logic                s1_hit_ff, s1_hit_in;
   logic [COUNT_W-1:0]  s1_fwd_ff;

   logic                out_valid_ff, out_valid_in;
   rsp_type             out_rsp_ff, out_rsp_in;

   logic                req_fire;
   logic                s1_adv;
   logic                is_tick;
   logic                tick_room;
   logic                seen;
   logic [CMP_W-1:0]    view_ext;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ADDR_W-1:0]   wr_addr;

   assign s1_adv    = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;

   assign is_tick   = (req_data.func == FUNC_TICK);
   assign tick_room = is_tick && (slots_ff < SLOT_W'(HISTORY_DEPTH));
   assign view_ext  = CMP_W'(req_data.view_index);
   assign rd_addr   = view_ext[ADDR_W-1:0];
   assign wr_addr   = slots_ff[ADDR_W-1:0];

   always_comb begin
      armed_in = armed_ff;
      count_in = count_ff;
      slots_in = slots_ff;
      done_in  = done_ff;
      seen     = 1'b0;
      if (is_tick) begin
         if (tick_room) begin
            if (count_ff == '0) begin
               done_in = 1'b1;
            end
            slots_in = slots_ff + SLOT_W'(1);
            count_in = '0;
         end
      end else begin
         if (req_data.sample > threshold_ff) begin
            armed_in = 1'b1;
         end else if (armed_ff && (req_data.sample < threshold_ff)) begin
            armed_in = 1'b0;
            seen     = 1'b1;
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
      end
   end

   always_comb begin
      s1_rsp_in                = '0;
      s1_rsp_in.bubble_seen    = seen;
      s1_rsp_in.period_count   = count_in;
      s1_rsp_in.periods_logged = LOGGED_W'(slots_in);
      s1_rsp_in.finished       = done_in;
      s1_view_ok_in            = view_ext < CMP_W'(slots_in);
      s1_hit_in                = tick_room && (view_ext == CMP_W'(slots_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         count_ff <= '0;
         slots_ff <= '0;
         done_ff  <= 1'b0;
      end else if (req_fire) begin
         armed_ff <= armed_in;
         count_ff <= count_in;
         slots_ff <= slots_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && tick_room) begin
         hist_mem[wr_addr] <= count_ff;
      end
      if (req_fire) begin
         rd_data_ff <= hist_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_rsp_ff     <= s1_rsp_in;
         s1_view_ok_ff <= s1_view_ok_in;
         s1_hit_ff     <= s1_hit_in;
         s1_fwd_ff     <= count_ff;
      end
   end

   always_comb begin
      out_rsp_in = s1_rsp_ff;
      if (!s1_view_ok_ff) begin
         out_rsp_in.viewed_count = '0;
      end else if (s1_hit_ff) begin
         out_rsp_in.viewed_count = s1_fwd_ff;
      end else begin
         out_rsp_in.viewed_count = rd_data_ff;
      end
   end

   always_comb begin
      priority if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      priority if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_rsp_ff;

   a_slot_advance: assert property (@(posedge clock) disable iff (reset)
      (req_fire && tick_room) |=> (slots_ff == $past(slots_ff) + SLOT_W'(1)) && (count_ff == '0))
      else $error("Slot counter or count wrong after a logged tick.");

   a_slots_bound: assert property (@(posedge clock) disable iff (reset)
      slots_ff <= SLOT_W'(HISTORY_DEPTH))
      else $error("Slot counter exceeds the history depth.");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff)
      else $error("Finished flag cleared without reset.");

   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_hit_ff) |-> s1_view_ok_ff)
      else $error("Forwarded history entry lies outside the written range.");

endmodule

### test/tb.sv
// Self-checking testbench for the bubble event counter with its per-period history log.
`timescale 1ns / 100ps

module tb;
   import bec_pkg::*;

   localparam int CLK_PERIOD  = 4;
   localparam int DEPTH       = 512;
   localparam int QUIET_LIMIT = 5000;
   localparam int PHASE_ITEMS = 60;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } table_row;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   req_type    req_data    = '0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   rsp_type    rsp_data;
   logic       csr_wr_en   = 1'b0;
   logic [7:0] csr_wr_data = '0;

   logic [SAMPLE_W-1:0] thr_now = THRESHOLD_RESET;
   logic                in_bubble = 1'b0;
   logic [COUNT_W-1:0]  bubble_count = '0;
   int                  logged_slots = 0;
   logic                finished_now = 1'b0;
   logic [COUNT_W-1:0]  log_mem [DEPTH];

   rsp_type  pending_rsp [$];
   table_row directed_rows [$];
   rsp_type  got_want;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int send_profile [4]  = '{0, 81, 0, 26};
   int stall_profile [4] = '{0, 0, 81, 26};
   int req_count     = 0;
   int rsp_count     = 0;
   int error_count   = 0;
   int quiet_cycles  = 0;

   bubble_event_counter_with_log_top #(
      .HISTORY_DEPTH(DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic rsp_type predict_bubble_rsp(req_type r);
      rsp_type p;
      p = '0;
      if (r.func == FUNC_TICK) begin
         if (logged_slots < DEPTH) begin
            log_mem[logged_slots] = bubble_count;
            if (bubble_count == 0) begin
               finished_now = 1'b1;
            end
            logged_slots++;
            bubble_count = '0;
         end
      end else begin
         if (r.sample > thr_now) begin
            in_bubble = 1'b1;
         end
         if (in_bubble && r.sample < thr_now) begin
            in_bubble = 1'b0;
            if (bubble_count != COUNT_MAX) begin
               bubble_count++;
            end
            p.bubble_seen = 1'b1;
         end
      end
      p.period_count   = bubble_count;
      p.periods_logged = LOGGED_W'(logged_slots);
      p.finished       = finished_now;
      if (r.view_index < logged_slots) begin
         p.viewed_count = log_mem[r.view_index];
      end
      return p;
   endfunction

   function automatic req_type make_random_request(int tick_pct);
      req_type r;
      int      roll;
      int      top;
      r.func = ($urandom_range(99) < tick_pct) ? FUNC_TICK : FUNC_SAMPLE;
      roll = $urandom_range(99);
      if (roll < 10) begin
         r.sample = thr_now;
      end else if (roll < 25) begin
         r.sample = SAMPLE_W'($urandom_range(255, 0));
      end else if (in_bubble && thr_now != 0) begin
         r.sample = SAMPLE_W'($urandom_range(thr_now - 1, 0));
      end else if (!in_bubble && thr_now != 255) begin
         r.sample = SAMPLE_W'($urandom_range(255, thr_now + 1));
      end else begin
         r.sample = SAMPLE_W'($urandom_range(255, 0));
      end
      top = (logged_slots < DEPTH) ? logged_slots : DEPTH;
      if (top > 0 && $urandom_range(99) < 70) begin
         r.view_index = VIEW_W'($urandom_range(top - 1, 0));
      end else begin
         r.view_index = VIEW_W'($urandom_range(511, 0));
      end
      return r;
   endfunction

   function automatic void add_row(func_type f, int s, int v, bit typed,
                                   int seen, int cnt, int lg, int fin, int vc);
      table_row row;
      row.req.func            = f;
      row.req.sample          = SAMPLE_W'(s);
      row.req.view_index      = VIEW_W'(v);
      row.typed               = typed;
      row.want.bubble_seen    = seen[0];
      row.want.period_count   = COUNT_W'(cnt);
      row.want.periods_logged = LOGGED_W'(lg);
      row.want.finished       = fin[0];
      row.want.viewed_count   = COUNT_W'(vc);
      directed_rows.push_back(row);
   endfunction

   task automatic send_request(req_type r, bit typed, rsp_type typed_rsp);
      rsp_type p;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      p = predict_bubble_rsp(r);
      pending_rsp.push_back(typed ? typed_rsp : p);
      req_count++;
   endtask

   task automatic wait_for_all_rsp();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   task automatic write_threshold(logic [7:0] value);
      wait_for_all_rsp();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      thr_now = value;
   endtask

   task automatic set_profile(int idx);
      send_idle_pct = send_profile[idx];
      stall_pct     = stall_profile[idx];
   endtask

   task automatic run_random(int n, bit pause_midway);
      for (int i = 0; i < n; i++) begin
         if (pause_midway && i == n / 2) begin
            wait_for_all_rsp();
         end
         send_request(make_random_request(50), 1'b0, '0);
      end
   endtask

   task automatic check_field(string field, logic [COUNT_W-1:0] want,
                              logic [COUNT_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            got_want = pending_rsp.pop_front();
            check_field("bubble_seen", COUNT_W'(got_want.bubble_seen),
                        COUNT_W'(rsp_data.bubble_seen));
            check_field("period_count", got_want.period_count, rsp_data.period_count);
            check_field("periods_logged", COUNT_W'(got_want.periods_logged),
                        COUNT_W'(rsp_data.periods_logged));
            check_field("finished", COUNT_W'(got_want.finished),
                        COUNT_W'(rsp_data.finished));
            check_field("viewed_count", got_want.viewed_count, rsp_data.viewed_count);
            rsp_count++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      int         k;
      int         extra;
      logic [7:0] phase_thr [4];

      // Samples equal to the threshold must leave every state bit untouched.
      add_row(FUNC_SAMPLE, 80, 0, 1, 0, 0, 0, 0, 0);
      add_row(FUNC_SAMPLE, 81, 511, 1, 0, 0, 0, 0, 0);
      add_row(FUNC_SAMPLE, 80, 0, 1, 0, 0, 0, 0, 0);
      add_row(FUNC_SAMPLE, 79, 0, 1, 1, 1, 0, 0, 0);
      add_row(FUNC_SAMPLE, 0, 0, 1, 0, 1, 0, 0, 0);
      add_row(FUNC_SAMPLE, 255, 0, 1, 0, 1, 0, 0, 0);
      add_row(FUNC_SAMPLE, 0, 0, 1, 1, 2, 0, 0, 0);
      // A tick viewing the slot it writes sees the new entry.
      add_row(FUNC_TICK, 255, 0, 1, 0, 0, 1, 0, 2);
      add_row(FUNC_TICK, 0, 1, 1, 0, 0, 2, 1, 0);
      add_row(FUNC_SAMPLE, 255, 0, 1, 0, 0, 2, 1, 2);
      add_row(FUNC_TICK, 0, 0, 1, 0, 0, 3, 1, 2);
      add_row(FUNC_SAMPLE, 0, 2, 1, 1, 1, 3, 1, 0);
      add_row(FUNC_SAMPLE, 255, 3, 1, 0, 1, 3, 1, 0);
      add_row(FUNC_SAMPLE, 0, 511, 1, 1, 2, 3, 1, 0);
      add_row(FUNC_TICK, 0, 3, 1, 0, 0, 4, 1, 2);
      add_row(FUNC_SAMPLE, 128, 3, 0, 0, 0, 0, 0, 0);
      add_row(FUNC_SAMPLE, 1, 2, 0, 0, 0, 0, 0, 0);
      add_row(FUNC_SAMPLE, 254, 1, 0, 0, 0, 0, 0, 0);
      add_row(FUNC_SAMPLE, 78, 0, 0, 0, 0, 0, 0, 0);
      add_row(FUNC_TICK, 170, 4, 0, 0, 0, 0, 0, 0);
      add_row(FUNC_SAMPLE, 85, 4, 0, 0, 0, 0, 0, 0);
      add_row(FUNC_SAMPLE, 42, 256, 0, 0, 0, 0, 0, 0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      end

      phase_thr[0] = 8'd255;
      phase_thr[1] = 8'd0;
      phase_thr[2] = 8'($urandom_range(230, 20));
      phase_thr[3] = 8'($urandom_range(230, 20));
      for (int p = 0; p < 4; p++) begin
         write_threshold(phase_thr[p]);
         set_profile(p);
         run_random(PHASE_ITEMS, p == 3);
      end

      // Fill the history and keep ticking once it is full.
      write_threshold(8'($urandom_range(180, 60)));
      k = 0;
      extra = 0;
      while (extra < 16) begin
         if (k % 64 == 0) begin
            set_profile((k / 64) % 4);
         end
         send_request(make_random_request(logged_slots < DEPTH ? 100 : 50), 1'b0, '0);
         if (logged_slots >= DEPTH) begin
            extra++;
         end
         k++;
      end

      wait_for_all_rsp();
      repeat (8) @(posedge clock);
      $display("tb: %0d requests sent, %0d responses checked, four handshake profiles",
               req_count, rsp_count);
      $display("tb: thresholds 0, 80, 255 and random; ticks past a full history; %0d slots logged",
               logged_slots);
      if (error_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
